// ===== hdl/i2ctrb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package i2ctrb_pkg;

  localparam int NUM_REGS = 32;
  localparam int PTR_W    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int OFF_W    = PTR_W + 1;
  localparam int SUM_W    = PTR_W + 2;
  localparam int LIM_W    = 6;
  localparam int CMP_W    = (SUM_W > LIM_W) ? SUM_W : LIM_W;

  localparam logic [LIM_W-1:0] RO_LIMIT_RST = 6'h10;
  localparam logic [LIM_W-1:0] WO_START_RST = 6'h18;

  localparam logic REG_RO_LIMIT = 1'b0;
  localparam logic REG_WO_START = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ADDRESS,
    PH_WRITE,
    PH_READ
  } phase_t;

  typedef enum logic [2:0] {
    MODE_WR_MATCH = 3'd0,
    MODE_RD_MATCH = 3'd1,
    MODE_RX       = 3'd2,
    MODE_TX       = 3'd3,
    MODE_BUS_ERR  = 3'd4
  } mode_t;

  typedef struct packed {
    logic [LIM_W-1:0] ro_limit;
    logic [LIM_W-1:0] wo_start;
  } cfg_t;

  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       ack;
    logic       restart_request;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/i2ctrb_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2ctrb_cfg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output i2ctrb_pkg::cfg_t       cfg
);
  import i2ctrb_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ro_limit <= RO_LIMIT_RST;
      cfg.wo_start <= WO_START_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_RO_LIMIT) begin
        cfg.ro_limit <= pwdata[LIM_W-1:0];
      end else begin
        cfg.wo_start <= pwdata[LIM_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_WO_START) begin
      prdata = {{(32-LIM_W){1'b0}}, cfg.wo_start};
    end else begin
      prdata = {{(32-LIM_W){1'b0}}, cfg.ro_limit};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/i2ctrb_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2ctrb_store (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire i2ctrb_pkg::store_wr_t        wr,
  input  wire logic [i2ctrb_pkg::PTR_W-1:0] rd_addr,
  output logic      [7:0]                   rd_data
);
  import i2ctrb_pkg::*;

  logic [7:0] regs [NUM_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= 8'(i);
      end
    end else if (wr.en) begin
      regs[wr.addr] <= wr.data;
    end
  end

  assign rd_data = regs[rd_addr];

endmodule

`default_nettype wire

// ===== hdl/i2ctrb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2ctrb_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         fire,
  input  wire logic [2:0]                   mode,
  input  wire logic [7:0]                   rx_byte,
  input  wire logic                         host_nacked,
  input  wire i2ctrb_pkg::cfg_t             cfg,
  input  wire logic [7:0]                   rd_data,
  output logic      [i2ctrb_pkg::PTR_W-1:0] rd_addr,
  output i2ctrb_pkg::store_wr_t             wr,
  output i2ctrb_pkg::result_t               res
);
  import i2ctrb_pkg::*;

  phase_t           phase, phase_next;
  logic [PTR_W-1:0] pointer, pointer_next;
  logic [OFF_W-1:0] offset, offset_next;

  logic [CMP_W-1:0] wr_idx, rd_idx, n_regs, ro_lim, wo_st;
  logic             rd_ok, wr_ok, rx_in_range;

  assign n_regs = CMP_W'(NUM_REGS);
  assign ro_lim = CMP_W'(cfg.ro_limit);
  assign wo_st  = CMP_W'(cfg.wo_start);
  assign wr_idx = CMP_W'(pointer) + CMP_W'(offset);

  always_comb begin
    if (mode == MODE_TX) begin
      rd_idx = CMP_W'(pointer) + CMP_W'(offset) + CMP_W'(1);
    end else begin
      rd_idx = CMP_W'(pointer);
    end
  end

  assign rd_ok       = (rd_idx < n_regs) && (rd_idx < wo_st);
  assign wr_ok       = (wr_idx < n_regs) && !(wr_idx < ro_lim);
  assign rx_in_range = {1'b0, rx_byte} < 9'(NUM_REGS);
  assign rd_addr     = rd_idx[PTR_W-1:0];

  always_comb begin
    phase_next   = phase;
    pointer_next = pointer;
    offset_next  = offset;
    case (mode)
      MODE_WR_MATCH: phase_next = PH_ADDRESS;
      MODE_RD_MATCH: begin
        offset_next = '0;
        phase_next  = rd_ok ? PH_READ : PH_IDLE;
      end
      MODE_RX: begin
        if (phase == PH_ADDRESS) begin
          if (rx_in_range) begin
            pointer_next = rx_byte[PTR_W-1:0];
            offset_next  = '0;
            phase_next   = PH_WRITE;
          end else begin
            phase_next = PH_IDLE;
          end
        end else if (phase == PH_WRITE) begin
          if (wr_ok) begin
            offset_next = offset + OFF_W'(1);
          end else begin
            phase_next = PH_IDLE;
          end
        end
      end
      MODE_TX: begin
        if (phase == PH_READ) begin
          if (rd_ok) begin
            offset_next = offset + OFF_W'(1);
          end else begin
            phase_next = PH_IDLE;
          end
        end
      end
      MODE_BUS_ERR: phase_next = PH_IDLE;
      default: ;
    endcase
  end

  always_comb begin
    res     = '0;
    wr.en   = 1'b0;
    wr.addr = wr_idx[PTR_W-1:0];
    wr.data = rx_byte;
    case (mode)
      MODE_WR_MATCH: res.ack = 1'b1;
      MODE_RD_MATCH, MODE_TX: begin
        if (mode == MODE_RD_MATCH || phase == PH_READ) begin
          if (rd_ok) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = rd_data;
            res.ack      = 1'b1;
          end else begin
            res.restart_request = 1'b1;
          end
        end
      end
      MODE_RX: begin
        if (phase == PH_ADDRESS) begin
          res.ack             = rx_in_range;
          res.restart_request = !rx_in_range;
        end else if (phase == PH_WRITE) begin
          wr.en               = fire && wr_ok;
          res.ack             = wr_ok;
          res.restart_request = !wr_ok;
        end
      end
      MODE_BUS_ERR: begin
        res.ack             = host_nacked;
        res.restart_request = !host_nacked;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      pointer <= '0;
      offset  <= '0;
    end else if (fire) begin
      phase   <= phase_next;
      pointer <= pointer_next;
      offset  <= offset_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/i2c_target_register_bank.sv =====
// channel  | direction | tdata (low bit up)                      | tuser
// s_*      | in        | rx_byte[7:0], host_nacked[8]            | mode[2:0]
// m_*      | out       | tx_byte[7:0], ack[8], restart_request[9] | tx_valid
// APB      | in        | read_only_limit @0x0, write_only_start @0x4
//
// A word is taken into the input register, then processed into the result
// register: one word per cycle while the output is not stalled.
// The input register drains only when the result register is free or taken.
// Reset clears the control state and reloads entry i of the store with i.
`timescale 1ns / 1ps
`default_nettype none

module i2c_target_register_bank (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // rx_byte[7:0], host_nacked[8]
  input  wire logic [2:0]  s_tuser,   // mode[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata,   // tx_byte[7:0], ack[8], restart_request[9]
  output logic      [0:0]  m_tuser,   // tx_valid[0]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import i2ctrb_pkg::*;

  logic             in_vld;
  logic [2:0]       in_mode;
  logic [7:0]       in_rx;
  logic             in_nack;
  logic             fire;
  cfg_t             cfg;
  store_wr_t        wr;
  logic [PTR_W-1:0] rd_addr;
  logic [7:0]       rd_data;
  result_t          res;

  assign fire     = in_vld && (!m_tvalid || m_tready);
  assign s_tready = !in_vld || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_mode <= s_tuser;
      in_rx   <= s_tdata[7:0];
      in_nack <= s_tdata[8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata    <= {6'b0, res.restart_request, res.ack, res.tx_byte};
      m_tuser[0] <= res.tx_valid;
    end
  end

  i2ctrb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  i2ctrb_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  i2ctrb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .mode        (in_mode),
    .rx_byte     (in_rx),
    .host_nacked (in_nack),
    .cfg         (cfg),
    .rd_data     (rd_data),
    .rd_addr     (rd_addr),
    .wr          (wr),
    .res         (res)
  );

endmodule

`default_nettype wire

// ===== tb/regbank_monitor.sv =====
`timescale 1ns / 1ps

module regbank_monitor
  import i2ctrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // rx_byte[7:0], host_nacked[8]
  input  logic [2:0]  s_tuser,   // mode[2:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // tx_byte[7:0], ack[8], restart_request[9]
  input  logic [0:0]  m_tuser,   // tx_valid[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          pending,
  output int          bytes_returned,
  output int          restarts_seen
);

  logic [7:0]       regs [NUM_REGS];
  logic [PTR_W-1:0] ptr;
  logic [OFF_W-1:0] offs;
  phase_t           ph;
  logic [LIM_W-1:0] ro_lim;
  logic [LIM_W-1:0] wo_st;
  result_t          reply_q [$];
  result_t          want;
  result_t          got;

  initial begin
    mismatches     = 0;
    pending        = 0;
    bytes_returned = 0;
    restarts_seen  = 0;
  end

  function automatic result_t predict_reply(input logic [2:0] md, input logic [7:0] rx,
                                            input logic nk);
    result_t r;
    int      idx;
    r = '0;
    case (md)
      MODE_WR_MATCH: begin
        ph = PH_ADDRESS;
        r.ack = 1'b1;
      end
      MODE_RD_MATCH: begin
        offs = '0;
        if (int'(ptr) >= NUM_REGS || int'(ptr) >= int'(wo_st)) begin
          ph = PH_IDLE;
          r.restart_request = 1'b1;
        end else begin
          ph = PH_READ;
          r.tx_valid = 1'b1;
          r.tx_byte  = regs[ptr];
          r.ack      = 1'b1;
        end
      end
      MODE_RX: begin
        if (ph == PH_ADDRESS) begin
          if (int'(rx) >= NUM_REGS) begin
            ph = PH_IDLE;
            r.restart_request = 1'b1;
          end else begin
            ptr  = rx[PTR_W-1:0];
            offs = '0;
            ph   = PH_WRITE;
            r.ack = 1'b1;
          end
        end else if (ph == PH_WRITE) begin
          idx = int'(ptr) + int'(offs);
          if (idx >= NUM_REGS || idx < int'(ro_lim)) begin
            ph = PH_IDLE;
            r.restart_request = 1'b1;
          end else begin
            regs[idx] = rx;
            offs = offs + 1'b1;
            r.ack = 1'b1;
          end
        end
      end
      MODE_TX: begin
        if (ph == PH_READ) begin
          idx = int'(ptr) + int'(offs) + 1;
          if (idx >= NUM_REGS || idx >= int'(wo_st)) begin
            ph = PH_IDLE;
            r.restart_request = 1'b1;
          end else begin
            offs = offs + 1'b1;
            r.tx_valid = 1'b1;
            r.tx_byte  = regs[idx];
            r.ack      = 1'b1;
          end
        end
      end
      MODE_BUS_ERR: begin
        ph = PH_IDLE;
        r.ack = nk;
        r.restart_request = !nk;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) regs[i] = i[7:0];
      ptr    = '0;
      offs   = '0;
      ph     = PH_IDLE;
      ro_lim = RO_LIMIT_RST;
      wo_st  = WO_START_RST;
      reply_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_RO_LIMIT) ro_lim = pwdata[LIM_W-1:0];
        else wo_st = pwdata[LIM_W-1:0];
      end
      if (s_tvalid && s_tready)
        reply_q.push_back(predict_reply(s_tuser, s_tdata[7:0], s_tdata[8]));
      if (m_tvalid && m_tready) begin
        got.tx_valid        = m_tuser[0];
        got.tx_byte         = m_tdata[7:0];
        got.ack             = m_tdata[8];
        got.restart_request = m_tdata[9];
        if (got.tx_valid) bytes_returned++;
        if (got.restart_request) restarts_seen++;
        if (reply_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected word valid=%0b byte=%02h ack=%0b restart=%0b",
                     $time, got.tx_valid, got.tx_byte, got.ack, got.restart_request);
          mismatches++;
        end else begin
          want = reply_q.pop_front();
          if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
              got.ack !== want.ack || got.restart_request !== want.restart_request) begin
            if (mismatches < 10)
              $display("%0t: want valid=%0b byte=%02h ack=%0b restart=%0b, got %0b %02h %0b %0b",
                       $time, want.tx_valid, want.tx_byte, want.ack, want.restart_request,
                       got.tx_valid, got.tx_byte, got.ack, got.restart_request);
            mismatches++;
          end
        end
      end
    end
    pending = reply_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import i2ctrb_pkg::*;

  localparam logic [2:0] MODE_SPARE_A = 3'd5;
  localparam logic [2:0] MODE_SPARE_B = 3'd6;
  localparam logic [2:0] MODE_SPARE_C = 3'd7;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int WORDS_PER_SETTING = 150;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int pending;
  int bytes_returned;
  int restarts_seen;
  int src_idle_pct = 13;
  int sink_idle_pct = 65;
  int stall_reqs = 0;
  int words_sent = 0;
  int quiet = 0;

  always #4 clk = ~clk;

  i2c_target_register_bank u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  regbank_monitor u_monitor (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .mismatches    (mismatches),
    .pending       (pending),
    .bytes_returned(bytes_returned),
    .restarts_seen (restarts_seen)
  );

  task automatic send_word(input logic [2:0] md, input logic [7:0] rx, input logic nk);
    bit taken;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= md;
    s_tdata  <= {7'd0, nk, rx};
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
    words_sent++;
  endtask

  task automatic apb_write(input logic sel, input logic [LIM_W-1:0] val);
    bit done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {{(32-LIM_W){1'b0}}, val};
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done = pready;
      @(posedge clk);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // drop valid, wait for every reply, then let the pipeline settle
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_burst();
    int kind;
    int n;
    logic [7:0] p;
    kind = $urandom_range(99);
    p = ($urandom_range(99) < 85) ? 8'($urandom_range(NUM_REGS-1))
                                  : 8'($urandom_range(255, NUM_REGS));
    if (kind < 40) begin
      send_word(MODE_WR_MATCH, 8'($urandom), 1'($urandom));
      send_word(MODE_RX, p, 1'($urandom));
      n = $urandom_range(6);
      repeat (n) send_word(MODE_RX, 8'($urandom), 1'($urandom));
      send_word(MODE_BUS_ERR, 8'($urandom), $urandom_range(9) != 0);
    end else if (kind < 90) begin
      if (kind < 70) begin
        send_word(MODE_WR_MATCH, 8'($urandom), 1'($urandom));
        send_word(MODE_RX, p, 1'($urandom));
      end
      send_word(MODE_RD_MATCH, 8'($urandom), 1'($urandom));
      n = $urandom_range(8);
      repeat (n) send_word(MODE_TX, 8'($urandom), 1'($urandom));
      send_word(MODE_BUS_ERR, 8'($urandom), $urandom_range(9) != 0);
    end else begin
      n = $urandom_range(4, 1);
      repeat (n) send_word(3'($urandom_range(7)), 8'($urandom), 1'($urandom));
    end
  endtask

  // receiver: random back-pressure, plus a long hold when asked
  initial begin
    int hold_left;
    int seen;
    hold_left = 0;
    seen = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (stall_reqs != seen) begin
        seen = stall_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int target;
    logic [LIM_W-1:0] ro_val;
    logic [LIM_W-1:0] wo_val;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // idle-phase strays and unused modes
    send_word(MODE_RX, 8'h55, 1'b0);
    send_word(MODE_TX, 8'h00, 1'b1);
    send_word(MODE_SPARE_A, 8'hFF, 1'b1);
    send_word(MODE_SPARE_B, 8'h00, 1'b0);
    send_word(MODE_SPARE_C, 8'hFF, 1'b1);
    // read from reset pointer, then normal end
    send_word(MODE_RD_MATCH, 8'h00, 1'b0);
    send_word(MODE_TX, 8'h00, 1'b0);
    send_word(MODE_BUS_ERR, 8'h00, 1'b1);
    // pointer out of range
    send_word(MODE_WR_MATCH, 8'h00, 1'b0);
    send_word(MODE_RX, 8'hFF, 1'b0);
    // write at the read-only edge, then abort
    send_word(MODE_WR_MATCH, 8'h00, 1'b0);
    send_word(MODE_RX, 8'd16, 1'b0);
    send_word(MODE_RX, 8'hA5, 1'b0);
    send_word(MODE_RX, 8'h5A, 1'b0);
    send_word(MODE_BUS_ERR, 8'h00, 1'b0);
    // write into read-only space
    send_word(MODE_WR_MATCH, 8'h00, 1'b0);
    send_word(MODE_RX, 8'd5, 1'b0);
    send_word(MODE_RX, 8'h00, 1'b0);
    // last register, then past the end
    send_word(MODE_WR_MATCH, 8'h00, 1'b0);
    send_word(MODE_RX, 8'd31, 1'b0);
    send_word(MODE_RX, 8'hFF, 1'b0);
    send_word(MODE_RX, 8'h01, 1'b0);
    // read up to the write-only edge
    send_word(MODE_WR_MATCH, 8'h00, 1'b0);
    send_word(MODE_RX, 8'd23, 1'b0);
    send_word(MODE_RD_MATCH, 8'h00, 1'b0);
    send_word(MODE_TX, 8'h00, 1'b0);
    // read start in write-only space
    send_word(MODE_WR_MATCH, 8'h00, 1'b0);
    send_word(MODE_RX, 8'd24, 1'b0);
    send_word(MODE_RD_MATCH, 8'h00, 1'b0);

    for (int ph = 0; ph < 6; ph++) begin
      src_idle_pct  = (ph < 2) ? 13 : (ph < 4) ? 65 : 0;
      sink_idle_pct = (ph < 2) ? 65 : (ph < 4) ? 13 : 0;
      if (ph > 0) begin
        case (ph)
          1:       begin ro_val = 6'd0;  wo_val = 6'd32; end
          2:       begin ro_val = 6'd32; wo_val = 6'd0;  end
          4:       begin ro_val = 6'd32; wo_val = 6'd32; end
          default: begin
            ro_val = LIM_W'($urandom_range(NUM_REGS));
            wo_val = LIM_W'($urandom_range(NUM_REGS));
          end
        endcase
        drain();
        apb_write(REG_RO_LIMIT, ro_val);
        apb_write(REG_WO_START, wo_val);
      end
      if (ph == 2 || ph == 4) stall_reqs++;
      target = words_sent + WORDS_PER_SETTING;
      while (words_sent < target) random_burst();
    end
    drain();

    $display("summary: %0d words over six register settings, %0d bytes returned, %0d restarts",
             words_sent, bytes_returned, restarts_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/i2ctrb_pkg.sv
hdl/i2ctrb_cfg.sv
hdl/i2ctrb_store.sv
hdl/i2ctrb_ctrl.sv
hdl/i2c_target_register_bank.sv
tb/regbank_monitor.sv
tb/tb_top.sv
